@@ rtl/core/qnrf_pkg.sv @@
// Package for the quintic Newton root finder: word format, register indexes,
// status codes and saturating helpers. No dependencies.
package qnrf_pkg;
  localparam int WordWidth = 48;
  localparam int FracBits  = 24;
  localparam int TolWidth  = 24;
  localparam int CapWidth  = 12;
  localparam int IdxWidth  = 4;
  localparam int QCntWidth = 7;

  typedef logic signed [WordWidth-1:0] word_t;

  localparam logic [IdxWidth-1:0] REG_C0  = 4'd0;
  localparam logic [IdxWidth-1:0] REG_C1  = 4'd1;
  localparam logic [IdxWidth-1:0] REG_C2  = 4'd2;
  localparam logic [IdxWidth-1:0] REG_C3  = 4'd3;
  localparam logic [IdxWidth-1:0] REG_C4  = 4'd4;
  localparam logic [IdxWidth-1:0] REG_C5  = 4'd5;
  localparam logic [IdxWidth-1:0] REG_TOL = 4'd6;
  localparam logic [IdxWidth-1:0] REG_CAP = 4'd7;

  localparam logic [1:0] ST_CONV = 2'd0;
  localparam logic [1:0] ST_DZERO = 2'd1;
  localparam logic [1:0] ST_CAP  = 2'd2;

  localparam word_t WMAX = {1'b0, {(WordWidth-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(WordWidth-1){1'b0}}};

  function automatic word_t sat_add(input word_t a, input word_t b);
    logic signed [WordWidth:0] s;
    s = {a[WordWidth-1], a} + {b[WordWidth-1], b};
    if (s[WordWidth] != s[WordWidth-1]) return s[WordWidth] ? WMIN : WMAX;
    return s[WordWidth-1:0];
  endfunction

  function automatic word_t sat_sub(input word_t a, input word_t b);
    logic signed [WordWidth:0] s;
    s = {a[WordWidth-1], a} - {b[WordWidth-1], b};
    if (s[WordWidth] != s[WordWidth-1]) return s[WordWidth] ? WMIN : WMAX;
    return s[WordWidth-1:0];
  endfunction

  // magnitude plus sign and overflow flag to saturated word
  function automatic word_t from_mag(input logic [WordWidth-1:0] m, input logic neg,
                                     input logic ovf);
    if (neg) begin
      if (ovf || m > {1'b1, {(WordWidth-1){1'b0}}}) return WMIN;
      return word_t'(-m);
    end
    if (ovf || m[WordWidth-1]) return WMAX;
    return word_t'(m);
  endfunction

  function automatic logic [WordWidth-1:0] mag(input word_t a);
    return a[WordWidth-1] ? -a : a;
  endfunction
endpackage

@@ rtl/core/qnrf_mul.sv @@
// Saturating Q24.24 multiplier, four 24x24 partial products accumulated in turn.
// Depends on qnrf_pkg.
module qnrf_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  qnrf_pkg::word_t     a,
  input  qnrf_pkg::word_t     b,
  output logic                done,
  output qnrf_pkg::word_t     prod
);
  localparam int H = qnrf_pkg::WordWidth / 2;
  localparam int W = qnrf_pkg::WordWidth;

  logic [W-1:0]   x_r, y_r;
  logic           neg_r;
  logic [2*W-1:0] acc_r, acc_nxt;
  logic [2:0]     step_r, step_nxt;
  logic           busy_r, busy_nxt;
  logic [H-1:0]   xs, ys;
  logic [2*H-1:0] pp;
  logic [2*W-1:0] pp_sh;

  always_comb begin
    xs = step_r[0] ? x_r[W-1:H] : x_r[H-1:0];
    ys = step_r[1] ? y_r[W-1:H] : y_r[H-1:0];
    pp = xs * ys;
    pp_sh = {{(2*W-2*H){1'b0}}, pp} << (H * (32'(step_r[0]) + 32'(step_r[1])));
    acc_nxt = acc_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    if (start) begin
      acc_nxt = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + pp_sh;
      step_nxt = step_r + 3'd1;
      if (step_r == 3'd3) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done   <= busy_r && step_r == 3'd3;
    end
    step_r <= step_nxt;
    acc_r  <= acc_nxt;
    if (start) begin
      x_r   <= qnrf_pkg::mag(a);
      y_r   <= qnrf_pkg::mag(b);
      neg_r <= a[W-1] ^ b[W-1];
    end
  end

  assign prod = qnrf_pkg::from_mag(acc_r[qnrf_pkg::FracBits +: W], neg_r,
                                   |acc_r[2*W-1:qnrf_pkg::FracBits+W]);
endmodule

@@ rtl/core/qnrf_div.sv @@
// Saturating Q24.24 divider, restoring, one quotient bit per cycle.
// Depends on qnrf_pkg.
module qnrf_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  qnrf_pkg::word_t     num,
  input  qnrf_pkg::word_t     den,
  output logic                done,
  output qnrf_pkg::word_t     quot
);
  localparam int W = qnrf_pkg::WordWidth;
  localparam int N = W + qnrf_pkg::FracBits;

  logic [N-1:0]   dvd_r;
  logic [W-1:0]   dm_r;
  logic [W:0]     rem_r, rem_sh;
  logic [N-1:0]   q_r;
  logic           neg_r, busy_r;
  logic [qnrf_pkg::QCntWidth-1:0] cnt_r;

  assign rem_sh = {rem_r[W-1:0], dvd_r[N-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) busy_r <= 1'b1;
      else if (busy_r) begin
        if (cnt_r == qnrf_pkg::QCntWidth'(N - 1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
    if (start) begin
      dvd_r <= {qnrf_pkg::mag(num), {qnrf_pkg::FracBits{1'b0}}};
      dm_r  <= qnrf_pkg::mag(den);
      neg_r <= num[W-1] ^ den[W-1];
      rem_r <= '0;
      q_r   <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      cnt_r <= cnt_r + 1'b1;
      if (rem_sh >= {1'b0, dm_r}) begin
        rem_r <= rem_sh - {1'b0, dm_r};
        q_r   <= {q_r[N-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r   <= {q_r[N-2:0], 1'b0};
      end
    end
  end

  assign quot = qnrf_pkg::from_mag(q_r[W-1:0], neg_r, |q_r[N-1:W]);
endmodule

@@ rtl/core/quintic_newton_root_finder.sv @@
// Newton-Raphson root finder for a quintic over saturating Q24.24.
// Per step: derivative (4 Horner mults), polynomial (5 mults), one divide;
// up to iteration_cap+1 steps per request. A zero derivative ends its step
// before the polynomial mults. One request at a time.
// Synchronous active-low reset restores coefficients 0, tolerance 17, cap 1000.
// Depends on qnrf_pkg, qnrf_mul, qnrf_div.
module quintic_newton_root_finder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [qnrf_pkg::IdxWidth-1:0]        cfg_index,
  input  logic [qnrf_pkg::WordWidth-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [qnrf_pkg::WordWidth-1:0] in_initial_guess,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [qnrf_pkg::WordWidth-1:0] out_root,
  output logic [1:0]                           out_status,
  output logic [qnrf_pkg::CapWidth-1:0]        out_iterations
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DMUL  = 7'b0000010,
    S_PMUL  = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_CHECK = 7'b0010000,
    S_OUT   = 7'b0100000,
    S_MWAIT = 7'b1000000
  } state_t;

  qnrf_pkg::word_t coef_r [6];
  logic [qnrf_pkg::TolWidth-1:0] tol_r;
  logic [qnrf_pkg::CapWidth-1:0] cap_r, j_r;
  state_t state_r, ret_r;
  qnrf_pkg::word_t x0_r, x1_r, acc_r, d_r;
  logic [2:0] k_r;
  logic first_r;
  logic pass_r;

  logic mstart, mdone, dstart, ddone;
  qnrf_pkg::word_t mprod, dquot, ma, mb;
  qnrf_pkg::word_t scaled, coef_k, step_dist, x1_new;
  logic [qnrf_pkg::WordWidth-1:0] dist_mag;

  qnrf_mul u_mul (.clk, .rst_n, .start(mstart), .a(ma), .b(mb), .done(mdone), .prod(mprod));
  qnrf_div u_div (.clk, .rst_n, .start(dstart), .num(acc_r), .den(d_r), .done(ddone),
                  .quot(dquot));

  // k * a_k by repeated saturating adds (k <= 5, narrow chain)
  always_comb begin
    coef_k = coef_r[k_r];
    scaled = '0;
    for (int t = 0; t < 5; t++)
      if (3'(t) < k_r) scaled = qnrf_pkg::sat_add(scaled, coef_k);
  end

  assign ma = acc_r;
  assign mb = x1_r;
  assign x1_new = qnrf_pkg::sat_sub(x1_r, dquot);
  assign step_dist = qnrf_pkg::sat_sub(x1_r, x0_r);
  assign dist_mag = (step_dist == qnrf_pkg::WMIN) ? qnrf_pkg::WMAX : qnrf_pkg::mag(step_dist);
  assign in_ready = state_r == S_IDLE;
  assign out_valid = state_r == S_OUT;
  assign mstart = (state_r == S_DMUL || state_r == S_PMUL) && ret_r != S_MWAIT;
  assign dstart = state_r == S_DIV && first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) coef_r[i] <= '0;
      tol_r   <= qnrf_pkg::TolWidth'(17);
      cap_r   <= qnrf_pkg::CapWidth'(1000);
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      first_r <= 1'b0;
      pass_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index <= qnrf_pkg::REG_C5) coef_r[cfg_index[2:0]] <= cfg_data;
        else if (cfg_index == qnrf_pkg::REG_TOL) tol_r <= cfg_data[qnrf_pkg::TolWidth-1:0];
        else if (cfg_index == qnrf_pkg::REG_CAP) cap_r <= cfg_data[qnrf_pkg::CapWidth-1:0];
      end
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          x1_r <= in_initial_guess;
          j_r  <= '0;
          state_r <= S_DMUL;
          k_r  <= 3'd4;
          ret_r <= S_IDLE;
          acc_r <= '0;
          first_r <= 1'b1;
          pass_r <= 1'b0;
        end
        S_DMUL: begin
          // derivative: acc = 5*a5 on entry, then acc*x + k*a_k for k=4..1
          if (first_r) begin
            k_r <= 3'd5;
            first_r <= 1'b0;
            ret_r <= S_MWAIT;
          end else if (ret_r == S_MWAIT && k_r == 3'd5) begin
            acc_r <= scaled;
            k_r <= 3'd4;
            ret_r <= S_IDLE;
          end else if (ret_r != S_MWAIT) begin
            ret_r <= S_MWAIT;
          end else if (mdone) begin
            acc_r <= qnrf_pkg::sat_add(mprod, scaled);
            if (k_r == 3'd1) begin
              d_r <= qnrf_pkg::sat_add(mprod, scaled);
              acc_r <= coef_r[5];
              k_r <= 3'd4;
              state_r <= S_PMUL;
            end else k_r <= k_r - 3'd1;
            ret_r <= S_IDLE;
          end
        end
        S_PMUL: begin
          if (d_r == '0) begin
            x1_r <= '0;
            state_r <= S_OUT;
            ret_r <= S_IDLE;
          end else if (ret_r != S_MWAIT) begin
            ret_r <= S_MWAIT;
          end else if (mdone) begin
            acc_r <= qnrf_pkg::sat_add(mprod, coef_k);
            if (k_r == 3'd0) begin
              state_r <= S_DIV;
              first_r <= 1'b1;
            end else k_r <= k_r - 3'd1;
            ret_r <= S_IDLE;
          end
        end
        S_DIV: begin
          first_r <= 1'b0;
          if (ddone) begin
            x0_r <= x1_r;
            x1_r <= x1_new;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          // first update is not counted; j counts passes after it
          if (pass_r) j_r <= j_r + 1'b1;
          state_r <= S_MWAIT;
        end
        S_MWAIT: begin
          if (dist_mag > {{(qnrf_pkg::WordWidth-qnrf_pkg::TolWidth){1'b0}}, tol_r}
              && j_r < cap_r) begin
            x0_r <= x1_r;
            state_r <= S_DMUL;
            first_r <= 1'b1;
            pass_r <= 1'b1;
          end else state_r <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          state_r <= S_IDLE;
          ret_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_root = x1_r;
  assign out_status = (state_r == S_OUT && d_r == '0) ? qnrf_pkg::ST_DZERO :
                      (j_r < cap_r) ? qnrf_pkg::ST_CONV : qnrf_pkg::ST_CAP;
  assign out_iterations = j_r;
endmodule
